// ===== design/sle_pkg.sv =====
package sle_pkg;

    localparam int DEF_CAPACITY = 16;

    // fixed field widths
    localparam int TYPE_W = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int FPOS_W = 4;
    localparam int LEN_W  = 5;

    localparam int S_TDATA_W = 72;  // value, upper_bound, position, 3 pad bits
    localparam int S_TUSER_W = TYPE_W;
    localparam int M_TDATA_W = 48;

    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_RANGE  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } sle_state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  list_length;
        logic [LEN_W-1:0]  removed_count;
        logic [WORD_W-1:0] read_value;
        logic [FPOS_W-1:0] found_position;
        logic [STAT_W-1:0] status;
    } sle_res_t;

endpackage

// ===== design/sle_mem.sv =====
module sle_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/sle_ctrl.sv =====
module sle_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sle_pkg::TYPE_W-1:0]   in_type,
    input  logic [sle_pkg::WORD_W-1:0]   in_value,
    input  logic [sle_pkg::WORD_W-1:0]   in_upper,
    input  logic [sle_pkg::POS_W-1:0]    in_pos,
    output logic                         mem_we,
    output logic [IDX_W-1:0]             mem_waddr,
    output logic [sle_pkg::WORD_W-1:0]   mem_wdata,
    output logic [IDX_W-1:0]             mem_raddr,
    input  logic [sle_pkg::WORD_W-1:0]   mem_rdata,
    output logic                         res_valid,
    input  logic                         res_take,
    output sle_pkg::sle_res_t            res
);
    import sle_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    sle_state_t        state_reg, state_next;
    logic [TYPE_W-1:0] op_reg, op_next;
    logic              noop_reg, noop_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  rd_left_reg, rd_left_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  fpos_reg, fpos_next;
    logic [WORD_W-1:0] rval_reg, rval_next;
    logic [STAT_W-1:0] status_reg, status_next;
    sle_res_t          res_reg, res_next;

    logic [CMP_W-1:0]  pos_x, cnt_x;
    logic              in_rng;

    assign pos_x = CMP_W'(in_pos);
    assign cnt_x = CMP_W'(count_reg);
    assign in_rng = ($signed(val_reg) <= $signed(mem_rdata)) &&
                    ($signed(mem_rdata) <= $signed(hi_reg));

    assign mem_raddr = rd_ptr_reg;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        noop_next      = noop_reg;
        val_next       = val_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_left_next   = rd_left_reg;
        pend_next      = 1'b0;
        pend_addr_next = rd_ptr_reg;
        count_next     = count_reg;
        keep_next      = keep_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        rval_next      = rval_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = mem_rdata;
        in_ready       = 1'b0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next   = S_RUN;
                    op_next      = in_type;
                    val_next     = in_value;
                    hi_next      = in_upper;
                    pos_next     = IDX_W'(in_pos);
                    rd_ptr_next  = '0;
                    rd_left_next = '0;
                    keep_next    = '0;
                    removed_next = '0;
                    found_next   = 1'b0;
                    fpos_next    = '0;
                    rval_next    = '0;
                    status_next  = ST_OK;
                    noop_next    = 1'b0;
                    case (in_type)
                        REQ_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                status_next = ST_FULL;
                                noop_next   = 1'b1;
                            end else if (pos_x > cnt_x) begin
                                status_next = ST_RANGE;
                                noop_next   = 1'b1;
                            end else begin
                                // walk from the tail down, each word moves up one
                                rd_ptr_next  = IDX_W'(count_reg - CNT_W'(1));
                                rd_left_next = count_reg - CNT_W'(in_pos);
                            end
                        end
                        REQ_FIND: begin
                            status_next  = ST_NOTFOUND;
                            rd_left_next = count_reg;
                        end
                        REQ_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ST_RANGE;
                                noop_next   = 1'b1;
                            end else begin
                                rd_ptr_next  = IDX_W'(CNT_W'(in_pos) + CNT_W'(1));
                                rd_left_next = count_reg - CNT_W'(in_pos) - CNT_W'(1);
                            end
                        end
                        REQ_RANGE: begin
                            rd_left_next = count_reg;
                        end
                        REQ_READ: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ST_RANGE;
                                noop_next   = 1'b1;
                            end else begin
                                rd_ptr_next  = IDX_W'(in_pos);
                                rd_left_next = CNT_W'(1);
                            end
                        end
                        default: begin
                            noop_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RUN: begin
                // issue one read per cycle
                if (rd_left_reg != '0) begin
                    pend_next    = 1'b1;
                    rd_left_next = rd_left_reg - CNT_W'(1);
                    if (op_reg == REQ_INSERT) begin
                        rd_ptr_next = rd_ptr_reg - IDX_W'(1);
                    end else begin
                        rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                    end
                end

                // read data is back in the next cycle; write targets never
                // collide with reads still in flight
                if (pend_reg) begin
                    case (op_reg)
                        REQ_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + IDX_W'(1);
                        end
                        REQ_REMOVE: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - IDX_W'(1);
                        end
                        REQ_FIND: begin
                            if (!found_reg && mem_rdata == val_reg) begin
                                found_next   = 1'b1;
                                fpos_next    = pend_addr_reg;
                                rd_left_next = '0;
                            end
                        end
                        REQ_RANGE: begin
                            if (in_rng) begin
                                removed_next = removed_reg + CNT_W'(1);
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'(keep_reg);
                                keep_next = keep_reg + CNT_W'(1);
                            end
                        end
                        REQ_READ: begin
                            rval_next = mem_rdata;
                        end
                        default: begin
                        end
                    endcase
                end

                if (rd_left_reg == '0 && !pend_reg) begin
                    state_next = S_FIN;
                    if (!noop_reg) begin
                        case (op_reg)
                            REQ_INSERT: begin
                                mem_we     = 1'b1;
                                mem_waddr  = pos_reg;
                                mem_wdata  = val_reg;
                                count_next = count_reg + CNT_W'(1);
                            end
                            REQ_REMOVE: begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            REQ_RANGE: begin
                                count_next = keep_reg;
                            end
                            REQ_FIND: begin
                                if (found_reg) begin
                                    status_next = ST_OK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    res_next.status         = (op_reg == REQ_FIND && found_reg) ?
                                              ST_OK : status_reg;
                    res_next.found_position = FPOS_W'(fpos_reg);
                    res_next.read_value     = rval_reg;
                    res_next.removed_count  = LEN_W'(removed_reg);
                    res_next.list_length    = LEN_W'(count_next);
                end
            end

            S_FIN: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        noop_reg      <= noop_next;
        val_reg       <= val_next;
        hi_reg        <= hi_next;
        pos_reg       <= pos_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_left_reg   <= rd_left_next;
        pend_addr_reg <= pend_addr_next;
        keep_reg      <= keep_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
        fpos_reg      <= fpos_next;
        rval_reg      <= rval_next;
        status_reg    <= status_next;
        res_reg       <= res_next;
    end
endmodule

// ===== design/sequential_list_engine_core.sv =====
// Channel | Dir | tdata (low bit up)                              | tuser
// s_      | in  | value[31:0] upper_bound[63:32] position[68:64]  | req_type[2:0]
// m_      | out | status[1:0] found_position[5:2] read_value[37:6]|
//         |     | removed_count[42:38] list_length[47:43]         | -
//
// One request at a time; each walks n entries (up to CAPACITY, a find stops one read
// past its match) at one memory read per cycle in S_RUN. Its word then passes through S_FIN
// into the output register, and the next request is taken once the controller is back in S_IDLE.
// Reset (aresetn low, synchronous) empties the list; memory contents are not cleared.
// A result waiting on m_tready does not block acceptance of the next request;
// that request finishes and then holds until the output register frees up.
module sequential_list_engine_core #(
    parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value, upper_bound, position, zero pad
    input  logic [sle_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [sle_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, found_position, read_value, removed_count, list_length
    output logic [sle_pkg::M_TDATA_W-1:0]  m_tdata
);
    import sle_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic              res_valid, res_take;
    sle_res_t          res;

    logic              m_tvalid_reg, m_tvalid_next;
    sle_res_t          m_res_reg;

    sle_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W),
        .DW    (WORD_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sle_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_value  (s_tdata[31:0]),
        .in_upper  (s_tdata[63:32]),
        .in_pos    (s_tdata[68:64]),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output word register
    assign res_take = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_take) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg;

    // a request is held for its whole run
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res_reg.list_length <= CAPACITY))
        else $error("list length beyond capacity");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_res_reg.status == ST_FULL |->
            m_res_reg.list_length == LEN_W'(CAPACITY))
        else $error("full status while list has room");

    a_removed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_res_reg.removed_count != '0 |-> m_res_reg.status == ST_OK)
        else $error("removal count with error status");
endmodule
